// ----- rtl/drce_pkg.sv -----
package drce_pkg;

    localparam int COUNT_WIDTH = 32;
    localparam int DELTA_WIDTH = COUNT_WIDTH + 1;
    localparam int RUN_WIDTH   = 32;
    localparam int GROUP_BITS  = 5;
    localparam int CHAR_WIDTH  = 7;
    localparam int LAG_INDEX   = 3;
    localparam int Q_DEPTH     = 2;
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);
    localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

    localparam logic [CHAR_WIDTH-1:0] CHAR_OFFSET = CHAR_WIDTH'(48);
    localparam logic [1:0]            IDX_MAX     = 2'(LAG_INDEX);

    typedef struct packed {
        logic [DELTA_WIDTH-1:0] delta;
        logic                   last;
    } t_work;

endpackage

// ----- rtl/drce_front.sv -----
module drce_front
    import drce_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [RUN_WIDTH-1:0] i_run_count,
    input  logic                 i_last_in_mask,
    input  logic                 i_full,
    output logic                 o_push,
    output t_work                o_work
);

    logic [1:0]             r_idx;
    logic [1:0]             n_idx;
    logic [COUNT_WIDTH-1:0] r_prev;
    logic [COUNT_WIDTH-1:0] n_prev;
    logic [COUNT_WIDTH-1:0] r_prev2;
    logic [COUNT_WIDTH-1:0] n_prev2;
    logic [COUNT_WIDTH-1:0] cnt;

    assign cnt    = i_run_count[COUNT_WIDTH-1:0];
    assign o_push = i_valid && !i_full;

    always_comb begin
        o_work.last = i_last_in_mask;
        if (r_idx == IDX_MAX) begin
            o_work.delta = {1'b0, cnt} - {1'b0, r_prev2};
        end else begin
            o_work.delta = {1'b0, cnt};
        end
    end

    always_comb begin
        n_idx   = r_idx;
        n_prev  = r_prev;
        n_prev2 = r_prev2;
        if (o_push) begin
            if (i_last_in_mask) begin
                n_idx   = '0;
                n_prev  = '0;
                n_prev2 = '0;
            end else begin
                n_prev2 = r_prev;
                n_prev  = cnt;
                if (r_idx != IDX_MAX) begin
                    n_idx = r_idx + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_prev  <= '0;
            r_prev2 <= '0;
        end else begin
            r_idx   <= n_idx;
            r_prev  <= n_prev;
            r_prev2 <= n_prev2;
        end
    end

endmodule

// ----- rtl/drce_queue.sv -----
module drce_queue
    import drce_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_work i_work,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_work o_work
);

    t_work              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wptr;
    logic [Q_PTR_W-1:0] r_rptr;
    logic [Q_CNT_W-1:0] r_cnt;
    logic [Q_CNT_W-1:0] n_cnt;

    assign o_full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_work  = r_mem[r_rptr];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + Q_CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wptr <= (r_wptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wptr + Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rptr + Q_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_work;
        end
    end

endmodule

// ----- rtl/drce_back.sv -----
module drce_back
    import drce_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    input  t_work                 i_work,
    output logic                  o_pop,
    output logic                  o_valid,
    output logic [CHAR_WIDTH-1:0] o_code_char,
    output logic                  o_last_char_of_count,
    output logic                  o_mask_done,
    input  logic                  i_stall
);

    logic                   r_busy;
    logic [DELTA_WIDTH-1:0] r_val;
    logic                   r_last;
    logic                   r_ovld;
    logic [CHAR_WIDTH-1:0]  r_char;
    logic                   r_end;
    logic                   r_done;
    logic                   load;
    logic                   emit;
    logic                   more;
    logic [GROUP_BITS-1:0]  grp;
    logic [DELTA_WIDTH-1:0] rest;

    assign grp  = r_val[GROUP_BITS-1:0];
    assign rest = DELTA_WIDTH'($signed(r_val) >>> GROUP_BITS);
    assign more = grp[GROUP_BITS-1] ? (rest != {DELTA_WIDTH{1'b1}}) : (rest != '0);
    assign load = !r_ovld || !i_stall;
    assign emit = r_busy && load;
    assign o_pop = i_q_valid && (!r_busy || (emit && !more));

    assign o_valid              = r_ovld;
    assign o_code_char          = r_char;
    assign o_last_char_of_count = r_end;
    assign o_mask_done          = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ovld <= 1'b0;
        end else begin
            if (emit) begin
                r_ovld <= 1'b1;
            end else if (load) begin
                r_ovld <= 1'b0;
            end
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (emit && !more) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_char <= CHAR_OFFSET + {1'b0, more, grp};
            r_end  <= !more;
            r_done <= !more && r_last;
        end
        if (o_pop) begin
            r_val  <= i_work.delta;
            r_last <= i_work.last;
        end else if (emit) begin
            r_val <= rest;
        end
    end

endmodule

// ----- rtl/delta_run_count_ascii_varint_encoder_top.sv -----
// A count's first character passes through a queue entry, the back-end value register
// and the output character register. Each count gives 1 to 7 output characters from
// the character serializer in the back end; a 2-entry queue decouples the input.
// Reset (synchronous, active low) clears the mask history, the queue and the output valid.
module delta_run_count_ascii_varint_encoder_top
    import drce_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [RUN_WIDTH-1:0]  i_run_count,
    input  logic                  i_last_in_mask,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [CHAR_WIDTH-1:0] o_code_char,
    output logic                  o_last_char_of_count,
    output logic                  o_mask_done
);

    logic  full;
    logic  push;
    logic  pop;
    logic  q_valid;
    t_work push_work;
    t_work pop_work;

    assign o_stall = full;

    drce_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_run_count    (i_run_count),
        .i_last_in_mask (i_last_in_mask),
        .i_full         (full),
        .o_push         (push),
        .o_work         (push_work)
    );

    drce_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_work  (push_work),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_work  (pop_work)
    );

    drce_back u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_q_valid            (q_valid),
        .i_work               (pop_work),
        .o_pop                (pop),
        .o_valid              (o_valid),
        .o_code_char          (o_code_char),
        .o_last_char_of_count (o_last_char_of_count),
        .o_mask_done          (o_mask_done),
        .i_stall              (i_stall)
    );

endmodule
